### hdl/uv_sphere_vertex_generator_defines.svh
// Assertion macros for the UV sphere vertex generator.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// Plain property, checked on every rising edge outside reset
`define SVG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("svg: property failed");

// Same-cycle implication
`define SVG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("svg: implication failed");

`endif

### hdl/svg_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the sphere vertex generator.
// No dependencies.
package svg_pkg;

    localparam int CW          = 34;   // CORDIC datapath width
    localparam int DIV_W       = 10;   // divider remainder/divisor width
    localparam int DIV_STAGES  = 8;
    localparam int DIV_STEPS   = 4;    // quotient bits per divider stage

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;
    localparam logic signed [15:0]   ONE_Q14  = 16'sd16384;

    localparam logic [1:0] CMD_RING   = 2'd0;
    localparam logic [1:0] CMD_TOP    = 2'd1;
    localparam logic [1:0] CMD_BOTTOM = 2'd2;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_STACKS = 2'd1;
    localparam logic [1:0] REG_SLICES = 2'd2;

    typedef enum logic [1:0] {
        KIND_RING,
        KIND_TOP,
        KIND_BOTTOM,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [14:0] tex_u;
        logic [14:0] tex_v;
    } meta_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] ring_index;
        logic [7:0] slice_index;
    } in_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic        [14:0] tex_u;
        logic        [14:0] tex_v;
        logic               index_error;
    } out_t;

    // atan(2^-i) in binary angle units (2^32 = one turn)
    function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] idx);
        case (idx)
            5'd0:    atan_turn = 34'sd536870912;
            5'd1:    atan_turn = 34'sd316933406;
            5'd2:    atan_turn = 34'sd167458907;
            5'd3:    atan_turn = 34'sd85004756;
            5'd4:    atan_turn = 34'sd42667331;
            5'd5:    atan_turn = 34'sd21354465;
            5'd6:    atan_turn = 34'sd10679838;
            5'd7:    atan_turn = 34'sd5340245;
            5'd8:    atan_turn = 34'sd2670163;
            5'd9:    atan_turn = 34'sd1335087;
            5'd10:   atan_turn = 34'sd667544;
            5'd11:   atan_turn = 34'sd333772;
            5'd12:   atan_turn = 34'sd166886;
            5'd13:   atan_turn = 34'sd83443;
            5'd14:   atan_turn = 34'sd41722;
            5'd15:   atan_turn = 34'sd20861;
            5'd16:   atan_turn = 34'sd10430;
            5'd17:   atan_turn = 34'sd5215;
            5'd18:   atan_turn = 34'sd2608;
            5'd19:   atan_turn = 34'sd1304;
            5'd20:   atan_turn = 34'sd652;
            5'd21:   atan_turn = 34'sd326;
            5'd22:   atan_turn = 34'sd163;
            5'd23:   atan_turn = 34'sd81;
            default: atan_turn = 34'sd0;
        endcase
    endfunction

endpackage

### hdl/svg_div.sv
// Pipelined restoring divider, two lanes, forming the theta and phi binary angles.
// Depends on svg_pkg.
module svg_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        pipe_en,
    input  logic                        in_valid,
    input  svg_pkg::meta_t              in_meta,
    input  logic [svg_pkg::DIV_W-1:0]   in_num [2],
    input  logic [svg_pkg::DIV_W-1:0]   in_den [2],
    output logic                        out_valid,
    output svg_pkg::meta_t              out_meta,
    output logic [31:0]                 out_quo [2]
);

    localparam int NS = svg_pkg::DIV_STAGES;
    localparam int DW = svg_pkg::DIV_W;

    logic                 valid_reg [NS];
    svg_pkg::meta_t       meta_reg  [NS];
    logic [DW-1:0]        rem_reg   [NS][2];
    logic [DW-1:0]        den_reg   [NS][2];
    logic [31:0]          quo_reg   [NS][2];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic           v_prev;
        svg_pkg::meta_t m_prev;

        if (k == 0) begin : g_first
            assign v_prev = in_valid;
            assign m_prev = in_meta;
        end else begin : g_rest
            assign v_prev = valid_reg[k-1];
            assign m_prev = meta_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (pipe_en) begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                meta_reg[k] <= m_prev;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DW-1:0] r_prev, d_prev, r_next;
            logic [31:0]   q_prev, q_next;

            if (k == 0) begin : g_first
                assign r_prev = in_num[l];
                assign d_prev = in_den[l];
                assign q_prev = '0;
            end else begin : g_rest
                assign r_prev = rem_reg[k-1][l];
                assign d_prev = den_reg[k-1][l];
                assign q_prev = quo_reg[k-1][l];
            end

            // shift in one zero numerator bit per step, subtract when it fits
            always_comb begin
                logic [DW:0] r2;
                r_next = r_prev;
                q_next = q_prev;
                for (int j = 0; j < svg_pkg::DIV_STEPS; j++) begin
                    r2 = {r_next, 1'b0};
                    if (r2 >= {1'b0, d_prev}) begin
                        q_next = {q_next[30:0], 1'b1};
                        r_next = DW'(r2 - {1'b0, d_prev});
                    end else begin
                        q_next = {q_next[30:0], 1'b0};
                        r_next = r2[DW-1:0];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    rem_reg[k][l] <= r_next;
                    den_reg[k][l] <= d_prev;
                    quo_reg[k][l] <= q_next;
                end
            end
        end
    end

    assign out_valid  = valid_reg[NS-1];
    assign out_meta   = meta_reg[NS-1];
    assign out_quo[0] = quo_reg[NS-1][0];
    assign out_quo[1] = quo_reg[NS-1][1];

endmodule

### hdl/svg_cordic.sv
// Pipelined rotation-mode CORDIC, two lanes (theta and phi), one iteration per stage.
// Depends on svg_pkg.
module svg_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pipe_en,
    input  logic               in_valid,
    input  svg_pkg::meta_t     in_meta,
    input  logic [31:0]        in_angle [2],
    output logic               out_valid,
    output svg_pkg::meta_t     out_meta,
    output logic signed [31:0] out_cos [2],
    output logic signed [31:0] out_sin [2]
);

    localparam int W = svg_pkg::CW;

    logic                valid_reg [CORDIC_STAGES];
    svg_pkg::meta_t      meta_reg  [CORDIC_STAGES];
    logic [1:0]          quad_reg  [CORDIC_STAGES][2];
    logic signed [W-1:0] x_reg     [CORDIC_STAGES][2];
    logic signed [W-1:0] y_reg     [CORDIC_STAGES][2];
    logic signed [W-1:0] z_reg     [CORDIC_STAGES][2];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        logic           v_prev;
        svg_pkg::meta_t m_prev;

        if (i == 0) begin : g_first
            assign v_prev = in_valid;
            assign m_prev = in_meta;
        end else begin : g_rest
            assign v_prev = valid_reg[i-1];
            assign m_prev = meta_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (pipe_en) begin
                valid_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                meta_reg[i] <= m_prev;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [W-1:0] x_prev, y_prev, z_prev;
            logic signed [W-1:0] x_next, y_next, z_next;
            logic [1:0]          q_prev;

            if (i == 0) begin : g_first
                // split off the quadrant, rotate the residual below a quarter turn
                assign x_prev = svg_pkg::GAIN_Q30;
                assign y_prev = '0;
                assign z_prev = $signed({4'b0000, in_angle[l][29:0]});
                assign q_prev = in_angle[l][31:30];
            end else begin : g_rest
                assign x_prev = x_reg[i-1][l];
                assign y_prev = y_reg[i-1][l];
                assign z_prev = z_reg[i-1][l];
                assign q_prev = quad_reg[i-1][l];
            end

            always_comb begin
                if (!z_prev[W-1]) begin
                    x_next = x_prev - (y_prev >>> i);
                    y_next = y_prev + (x_prev >>> i);
                    z_next = z_prev - svg_pkg::atan_turn(5'(i));
                end else begin
                    x_next = x_prev + (y_prev >>> i);
                    y_next = y_prev - (x_prev >>> i);
                    z_next = z_prev + svg_pkg::atan_turn(5'(i));
                end
            end

            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    x_reg[i][l]    <= x_next;
                    y_reg[i][l]    <= y_next;
                    z_reg[i][l]    <= z_next;
                    quad_reg[i][l] <= q_prev;
                end
            end
        end
    end

    // final stage: clamp to +-1.0 and fold the quadrant back in
    logic                valid_out_reg;
    svg_pkg::meta_t      meta_out_reg;
    logic signed [31:0]  cos_reg [2];
    logic signed [31:0]  sin_reg [2];

    for (genvar l = 0; l < 2; l++) begin : g_fold
        logic signed [W-1:0] xc, yc;
        logic signed [31:0]  c_next, s_next;

        always_comb begin
            xc = x_reg[CORDIC_STAGES-1][l];
            yc = y_reg[CORDIC_STAGES-1][l];
            if (xc > svg_pkg::ONE_Q30)       xc = svg_pkg::ONE_Q30;
            else if (xc < -svg_pkg::ONE_Q30) xc = -svg_pkg::ONE_Q30;
            if (yc > svg_pkg::ONE_Q30)       yc = svg_pkg::ONE_Q30;
            else if (yc < -svg_pkg::ONE_Q30) yc = -svg_pkg::ONE_Q30;
            case (quad_reg[CORDIC_STAGES-1][l])
                2'd0: begin
                    c_next = xc[31:0];
                    s_next = yc[31:0];
                end
                2'd1: begin
                    c_next = -yc[31:0];
                    s_next = xc[31:0];
                end
                2'd2: begin
                    c_next = -xc[31:0];
                    s_next = -yc[31:0];
                end
                default: begin
                    c_next = yc[31:0];
                    s_next = -xc[31:0];
                end
            endcase
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                cos_reg[l] <= c_next;
                sin_reg[l] <= s_next;
            end
        end

        assign out_cos[l] = cos_reg[l];
        assign out_sin[l] = sin_reg[l];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out_reg <= 1'b0;
        end else if (pipe_en) begin
            valid_out_reg <= valid_reg[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            meta_out_reg <= meta_reg[CORDIC_STAGES-1];
        end
    end

    assign out_valid = valid_out_reg;
    assign out_meta  = meta_out_reg;

endmodule

### hdl/svg_out.sv
// Product, scaling and rounding stages plus the output register and skid buffer.
// Depends on svg_pkg and uv_sphere_vertex_generator_defines.svh.
`include "uv_sphere_vertex_generator_defines.svh"

module svg_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  svg_pkg::meta_t     in_meta,
    input  logic signed [31:0] cos_t,
    input  logic signed [31:0] sin_t,
    input  logic signed [31:0] cos_p,
    input  logic signed [31:0] sin_p,
    input  logic [15:0]        radius,
    output logic               pipe_en,
    output logic               m_valid,
    input  logic               m_ready,
    output svg_pkg::out_t      m_data
);

    function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
        logic signed [32:0] s;
        logic signed [16:0] t;
        s = {v[31], v} + 33'sd32768;
        t = s[32:16];
        if (t > 17'sd16384)       to_q14 = 16'sd16384;
        else if (t < -17'sd16384) to_q14 = -16'sd16384;
        else                      to_q14 = t[15:0];
    endfunction

    function automatic logic signed [15:0] to_q8(input logic signed [48:0] p);
        logic signed [49:0] s;
        logic signed [19:0] t;
        s = {p[48], p} + 50'sd536870912;
        t = s[49:30];
        if (t > 20'sd32767)       to_q8 = 16'sd32767;
        else if (t < -20'sd32768) to_q8 = -16'sd32768;
        else                      to_q8 = t[15:0];
    endfunction

    logic           skid_valid_reg;
    svg_pkg::out_t  skid_data_reg;
    logic           m_valid_reg;
    svg_pkg::out_t  m_data_reg;

    assign pipe_en = !skid_valid_reg;

    // P1: sin(theta) times cos/sin(phi); poles force sin(theta)=0, cos(theta)=+-1
    logic signed [31:0] st_use, ct_use;
    logic signed [63:0] px_next, pz_next;

    always_comb begin
        st_use = sin_t;
        ct_use = cos_t;
        if (in_meta.kind == svg_pkg::KIND_TOP) begin
            st_use = '0;
            ct_use = svg_pkg::ONE_Q30[31:0];
        end else if (in_meta.kind == svg_pkg::KIND_BOTTOM) begin
            st_use = '0;
            ct_use = -svg_pkg::ONE_Q30[31:0];
        end
    end

    assign px_next = st_use * cos_p;
    assign pz_next = st_use * sin_p;

    logic               p1_valid_reg;
    svg_pkg::meta_t     p1_meta_reg;
    logic signed [63:0] p1_px_reg, p1_pz_reg;
    logic signed [31:0] p1_ct_reg, p1_cp_reg, p1_sp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            p1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p1_meta_reg <= in_meta;
            p1_px_reg   <= px_next;
            p1_pz_reg   <= pz_next;
            p1_ct_reg   <= ct_use;
            p1_cp_reg   <= cos_p;
            p1_sp_reg   <= sin_p;
        end
    end

    // P2: floor to Q30, scale by the radius
    logic signed [31:0] nx, nz;
    logic signed [16:0] rad_s;
    logic signed [48:0] rx_next, ry_next, rz_next;

    assign nx      = p1_px_reg[61:30];
    assign nz      = p1_pz_reg[61:30];
    assign rad_s   = $signed({1'b0, radius});
    assign rx_next = rad_s * nx;
    assign ry_next = rad_s * p1_ct_reg;
    assign rz_next = rad_s * nz;

    logic               p2_valid_reg;
    svg_pkg::meta_t     p2_meta_reg;
    logic signed [48:0] p2_rx_reg, p2_ry_reg, p2_rz_reg;
    logic signed [31:0] p2_nx_reg, p2_nz_reg, p2_ct_reg, p2_cp_reg, p2_sp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p2_meta_reg <= p1_meta_reg;
            p2_rx_reg   <= rx_next;
            p2_ry_reg   <= ry_next;
            p2_rz_reg   <= rz_next;
            p2_nx_reg   <= nx;
            p2_nz_reg   <= nz;
            p2_ct_reg   <= p1_ct_reg;
            p2_cp_reg   <= p1_cp_reg;
            p2_sp_reg   <= p1_sp_reg;
        end
    end

    // P3: round, clamp and assemble the result
    svg_pkg::out_t res_next;

    always_comb begin
        res_next             = '0;
        res_next.pos_x       = to_q8(p2_rx_reg);
        res_next.pos_y       = to_q8(p2_ry_reg);
        res_next.pos_z       = to_q8(p2_rz_reg);
        res_next.normal_x    = to_q14(p2_nx_reg);
        res_next.normal_y    = to_q14(p2_ct_reg);
        res_next.normal_z    = to_q14(p2_nz_reg);
        res_next.tangent_x   = to_q14(-p2_sp_reg);
        res_next.tangent_y   = '0;
        res_next.tangent_z   = to_q14(p2_cp_reg);
        res_next.tex_u       = p2_meta_reg.tex_u;
        res_next.tex_v       = p2_meta_reg.tex_v;
        res_next.index_error = 1'b0;
        case (p2_meta_reg.kind)
            svg_pkg::KIND_TOP, svg_pkg::KIND_BOTTOM: begin
                res_next.tangent_x = svg_pkg::ONE_Q14;
                res_next.tangent_z = '0;
            end
            svg_pkg::KIND_ERROR: begin
                res_next             = '0;
                res_next.index_error = 1'b1;
            end
            default: ;
        endcase
    end

    // output register; skid takes a result that arrives while the main one stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg    <= p2_valid_reg;
            end
        end else if (p2_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : res_next;
        end else if (pipe_en && p2_valid_reg) begin
            skid_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SVG_ASSERT_IMPL(a_skid_behind_main, aclk, aresetn, skid_valid_reg, m_valid_reg)
    `SVG_ASSERT_IMPL(a_error_zeroes, aclk, aresetn, m_valid_reg && m_data_reg.index_error, m_data_reg.pos_x == 16'sd0 && m_data_reg.normal_y == 16'sd0 && m_data_reg.tex_v == 15'd0)
    `SVG_ASSERT(a_normal_y_range, aclk, aresetn, m_valid_reg |-> (m_data_reg.normal_y <= 16'sd16384 && m_data_reg.normal_y >= -16'sd16384))

endmodule

### hdl/uv_sphere_vertex_generator.sv
// UV sphere vertex generator, top level. An accepted transaction passes the stage 0
// register, the divider, the CORDIC, the P1 and P2 registers and the output register.
// Throughput: one transaction per cycle; the pipeline halts only while the output
// skid register is occupied. Reset (aresetn low, synchronous) empties the pipeline
// and loads radius 1.0, 16 stacks and 16 slices. No clearing pass is needed.
// Depends on svg_pkg, svg_div, svg_cordic and svg_out.
module uv_sphere_vertex_generator #(
    parameter int MAX_SEGMENTS  = 256,
    parameter int CORDIC_STAGES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration writes
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata,
    // vertex requests
    input  logic              s_valid,
    output logic              s_ready,
    input  svg_pkg::in_t      s_data,
    // vertex results
    output logic              m_valid,
    input  logic              m_ready,
    output svg_pkg::out_t     m_data
);

    localparam int DW = svg_pkg::DIV_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] radius_reg;
    logic [8:0]  stacks_reg;
    logic [8:0]  slices_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 16'd256;
            stacks_reg <= 9'd16;
            slices_reg <= 9'd16;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                svg_pkg::REG_RADIUS: radius_reg <= cfg_wdata;
                svg_pkg::REG_STACKS: stacks_reg <= cfg_wdata[8:0];
                svg_pkg::REG_SLICES: slices_reg <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // One enable advances every stage together; it drops only while the
    // output skid register holds a result, so nothing is lost or repeated.
    logic pipe_en;

    assign s_ready = pipe_en;

    // ------------------------------------------------------------------
    // Stage 0: classify the request and set up the two divisions.
    //   theta = (ring+1) * 2^32 / (2*stacks)  (same as (ring+1)*2^31/stacks)
    //   phi   = slice * 2^32 / slices
    // ------------------------------------------------------------------
    logic [8:0]     ring1;
    logic           bad_ring;
    svg_pkg::kind_t kind_next;
    logic [DW-1:0]  num_next [2];
    logic [DW-1:0]  den_next [2];

    assign ring1 = {1'b0, s_data.ring_index} + 9'd1;

    always_comb begin
        bad_ring = (stacks_reg < 9'd2) || (slices_reg == 9'd0)
                || ({23'd0, stacks_reg} > 32'(MAX_SEGMENTS))
                || ({23'd0, slices_reg} > 32'(MAX_SEGMENTS))
                || (ring1 >= stacks_reg)
                || ({1'b0, s_data.slice_index} >= slices_reg);
        unique case (s_data.command)
            svg_pkg::CMD_RING:   kind_next = bad_ring ? svg_pkg::KIND_ERROR
                                                      : svg_pkg::KIND_RING;
            svg_pkg::CMD_TOP:    kind_next = svg_pkg::KIND_TOP;
            svg_pkg::CMD_BOTTOM: kind_next = svg_pkg::KIND_BOTTOM;
            default:             kind_next = svg_pkg::KIND_ERROR;
        endcase
        // feed the dividers harmless operands when the quotients go unused
        if (kind_next == svg_pkg::KIND_RING) begin
            num_next[0] = {1'b0, ring1};
            den_next[0] = {stacks_reg, 1'b0};
            num_next[1] = {2'b00, s_data.slice_index};
            den_next[1] = {1'b0, slices_reg};
        end else begin
            num_next[0] = '0;
            den_next[0] = DW'(1);
            num_next[1] = '0;
            den_next[1] = DW'(1);
        end
    end

    logic           s0_valid_reg;
    svg_pkg::meta_t s0_meta_reg;
    logic [DW-1:0]  s0_num_reg [2];
    logic [DW-1:0]  s0_den_reg [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s0_meta_reg.kind  <= kind_next;
            s0_meta_reg.tex_u <= '0;
            s0_meta_reg.tex_v <= '0;
            s0_num_reg        <= num_next;
            s0_den_reg        <= den_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider: eight stages, four quotient bits each
    // ------------------------------------------------------------------
    logic           dv_valid;
    svg_pkg::meta_t dv_meta;
    logic [31:0]    dv_quo [2];

    svg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (s0_valid_reg),
        .in_meta   (s0_meta_reg),
        .in_num    (s0_num_reg),
        .in_den    (s0_den_reg),
        .out_valid (dv_valid),
        .out_meta  (dv_meta),
        .out_quo   (dv_quo)
    );

    // For ring vertices the texture coordinates fall straight out of the angles:
    // u = theta / 2^18 and v = phi / 2^17 (nested floors agree).
    svg_pkg::meta_t tex_meta;

    always_comb begin
        tex_meta = dv_meta;
        case (dv_meta.kind)
            svg_pkg::KIND_RING: begin
                tex_meta.tex_u = {1'b0, dv_quo[0][31:18]};
                tex_meta.tex_v = dv_quo[1][31:17];
            end
            svg_pkg::KIND_BOTTOM: begin
                tex_meta.tex_u = '0;
                tex_meta.tex_v = 15'd16384;
            end
            default: begin
                tex_meta.tex_u = '0;
                tex_meta.tex_v = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // CORDIC: lane 0 theta, lane 1 phi
    // ------------------------------------------------------------------
    logic               cd_valid;
    svg_pkg::meta_t     cd_meta;
    logic signed [31:0] cd_cos [2];
    logic signed [31:0] cd_sin [2];

    svg_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (dv_valid),
        .in_meta   (tex_meta),
        .in_angle  (dv_quo),
        .out_valid (cd_valid),
        .out_meta  (cd_meta),
        .out_cos   (cd_cos),
        .out_sin   (cd_sin)
    );

    // ------------------------------------------------------------------
    // Products, rounding, output register and skid
    // ------------------------------------------------------------------
    svg_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (cd_valid),
        .in_meta  (cd_meta),
        .cos_t    (cd_cos[0]),
        .sin_t    (cd_sin[0]),
        .cos_p    (cd_cos[1]),
        .sin_p    (cd_sin[1]),
        .radius   (radius_reg),
        .pipe_en  (pipe_en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
